// File: src/fenwick_prefix_sum_table_core_assert.svh
// Assertion macros used by the port checker of the prefix sum table core.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef FENWICK_PREFIX_SUM_TABLE_CORE_ASSERT_SVH
`define FENWICK_PREFIX_SUM_TABLE_CORE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define FPST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define FPST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: src/fpst_pkg.sv
// Shared types and constants of the prefix sum table core.
// Depends on nothing; used by every module of the block.
package fpst_pkg;

  localparam int CAPACITY_DEFAULT = 1024;
  localparam int POS_W            = 11;
  localparam int DATA_W           = 32;

  localparam logic [POS_W-1:0] ACTIVE_SIZE_RESET = 11'd1024;

  localparam logic CMD_QUERY  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_RESULT
  } fpst_state_e;

  typedef struct packed {
    logic in_ready;
    logic res_valid;
  } walk_status_t;

endpackage

// File: src/fenwick_prefix_sum_table_core.sv
// Top level of the binary indexed prefix sum table: size register and result register.
// Depends on fpst_pkg, fpst_walker and fpst_tree_ram.
//
//   channel   signals                                   direction
//   request   in_valid_i/in_ready_o, command, position, delta   in
//   result    out_valid_o/out_ready_i, prefix_sum_o     out
//   config    cfg_we_i, cfg_wdata_i (active size)       in
//
// The walk of a request visits at most log2(CAPACITY) + 1 tree entries, one entry
// per cycle through the single read port of the counter store. A walk may also
// visit no entry at all.
// After reset a clearing pass zeroes the store; no request
// is taken meanwhile, while configuration writes are taken at any time.
// A finished query waits in the walker only while the result register is full.
module fenwick_prefix_sum_table_core #(
  parameter int CAPACITY = fpst_pkg::CAPACITY_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 command_i,
  input  logic        [fpst_pkg::POS_W-1:0]    position_i,
  input  logic signed [fpst_pkg::DATA_W-1:0]   delta_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [fpst_pkg::DATA_W-1:0]   prefix_sum_o,
  input  logic                                 cfg_we_i,
  input  logic        [fpst_pkg::POS_W-1:0]    cfg_wdata_i
);

  localparam int AW = $clog2(CAPACITY);

  fpst_pkg::walk_status_t      status;
  logic [fpst_pkg::POS_W-1:0]  active_size_q;
  logic                        out_valid_q;
  logic [fpst_pkg::DATA_W-1:0] prefix_sum_q;
  logic [fpst_pkg::DATA_W-1:0] sum;
  logic                        res_take;
  logic                        start;

  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [fpst_pkg::DATA_W-1:0] ram_wdata, ram_rdata;

  assign start    = in_valid_i && status.in_ready;
  assign res_take = status.res_valid && (!out_valid_q || out_ready_i);

  fpst_walker #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_walker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .command_i     (command_i),
    .position_i    (position_i),
    .delta_i       ($unsigned(delta_i)),
    .active_size_i (active_size_q),
    .res_take_i    (res_take),
    .status_o      (status),
    .sum_o         (sum),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata)
  );

  fpst_tree_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_size_q <= fpst_pkg::ACTIVE_SIZE_RESET;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        active_size_q <= cfg_wdata_i;
      end
      if (res_take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      prefix_sum_q <= sum;
    end
  end

  assign in_ready_o   = status.in_ready;
  assign out_valid_o  = out_valid_q;
  assign prefix_sum_o = $signed(prefix_sum_q);

endmodule

// File: src/fpst_tree_ram.sv
// Single-port-write, single-port-read counter store with registered read data.
// Depends on fpst_pkg for the data width.
module fpst_tree_ram #(
  parameter int DEPTH = fpst_pkg::CAPACITY_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [fpst_pkg::DATA_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [fpst_pkg::DATA_W-1:0] rdata_o
);

  logic [fpst_pkg::DATA_W-1:0] mem [DEPTH];
  logic [fpst_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/fpst_walker.sv
// Sequencer of the tree walk: clearing pass, index stepping and the shared adder.
// Depends on fpst_pkg; drives the counter store in fpst_tree_ram.
module fpst_walker #(
  parameter int CAPACITY = fpst_pkg::CAPACITY_DEFAULT,
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          command_i,
  input  logic [fpst_pkg::POS_W-1:0]    position_i,
  input  logic [fpst_pkg::DATA_W-1:0]   delta_i,
  input  logic [fpst_pkg::POS_W-1:0]    active_size_i,
  input  logic                          res_take_i,
  output fpst_pkg::walk_status_t        status_o,
  output logic [fpst_pkg::DATA_W-1:0]   sum_o,
  output logic                          ram_we_o,
  output logic [AW-1:0]                 ram_waddr_o,
  output logic [fpst_pkg::DATA_W-1:0]   ram_wdata_o,
  output logic                          ram_re_o,
  output logic [AW-1:0]                 ram_raddr_o,
  input  logic [fpst_pkg::DATA_W-1:0]   ram_rdata_i
);

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int KW = ((IW > fpst_pkg::POS_W) ? IW : fpst_pkg::POS_W) + 1;
  localparam logic [KW-1:0] CAP_K    = KW'(CAPACITY);
  localparam logic [AW-1:0] CLR_LAST = AW'(CAPACITY - 1);

  fpst_pkg::fpst_state_e state_q, state_d;
  logic [AW-1:0]               clr_q, clr_d;
  logic                        pend_q, pend_d;
  logic [KW-1:0]               k_q, k_d;
  logic [AW-1:0]               paddr_q, paddr_d;
  logic [fpst_pkg::DATA_W-1:0] acc_q, acc_d;
  logic                        cmd_q, cmd_d;
  logic [fpst_pkg::DATA_W-1:0] delta_q, delta_d;
  logic [KW-1:0]               lim_q, lim_d;

  logic [KW-1:0]               act_ext, pos_ext, lim_new;
  logic [KW-1:0]               lowbit, k_next;
  logic                        issue_ok;
  logic [fpst_pkg::DATA_W-1:0] add_b, add_y;

  assign act_ext = KW'(active_size_i);
  assign pos_ext = KW'(position_i);
  assign lim_new = (act_ext > CAP_K) ? CAP_K : act_ext;

  assign lowbit   = k_q & (~k_q + KW'(1));
  assign k_next   = (cmd_q == fpst_pkg::CMD_QUERY) ? (k_q & (k_q - KW'(1))) : (k_q + lowbit);
  assign issue_ok = (k_q != '0) && ((cmd_q == fpst_pkg::CMD_QUERY) || (k_q <= lim_q));

  assign add_b = (cmd_q == fpst_pkg::CMD_UPDATE) ? delta_q : acc_q;
  assign add_y = ram_rdata_i + add_b;

  assign ram_re_o    = (state_q == fpst_pkg::ST_WALK) && issue_ok;
  assign ram_raddr_o = AW'(k_q - KW'(1));
  assign ram_we_o    = (state_q == fpst_pkg::ST_CLEAR) ||
                       ((state_q == fpst_pkg::ST_WALK) && pend_q &&
                        (cmd_q == fpst_pkg::CMD_UPDATE));
  assign ram_waddr_o = (state_q == fpst_pkg::ST_CLEAR) ? clr_q : paddr_q;
  assign ram_wdata_o = (state_q == fpst_pkg::ST_CLEAR) ? '0 : add_y;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    pend_d   = pend_q;
    k_d      = k_q;
    paddr_d  = paddr_q;
    acc_d    = acc_q;
    cmd_d    = cmd_q;
    delta_d  = delta_q;
    lim_d    = lim_q;
    status_o = '0;
    unique case (state_q)
      fpst_pkg::ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = fpst_pkg::ST_IDLE;
        end
      end
      fpst_pkg::ST_IDLE: begin
        status_o.in_ready = 1'b1;
        if (start_i) begin
          cmd_d   = command_i;
          delta_d = delta_i;
          lim_d   = lim_new;
          acc_d   = '0;
          pend_d  = 1'b0;
          if (command_i == fpst_pkg::CMD_QUERY) begin
            k_d = (pos_ext > lim_new) ? lim_new : pos_ext;
          end else begin
            k_d = pos_ext;
          end
          state_d = fpst_pkg::ST_WALK;
        end
      end
      fpst_pkg::ST_WALK: begin
        pend_d = issue_ok;
        if (issue_ok) begin
          k_d     = k_next;
          paddr_d = ram_raddr_o;
        end
        if (pend_q && (cmd_q == fpst_pkg::CMD_QUERY)) begin
          acc_d = add_y;
        end
        if (!issue_ok && !pend_q) begin
          state_d = (cmd_q == fpst_pkg::CMD_QUERY) ? fpst_pkg::ST_RESULT : fpst_pkg::ST_IDLE;
        end
      end
      fpst_pkg::ST_RESULT: begin
        status_o.res_valid = 1'b1;
        if (res_take_i) begin
          state_d = fpst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fpst_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpst_pkg::ST_CLEAR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    paddr_q <= paddr_d;
    acc_q   <= acc_d;
    cmd_q   <= cmd_d;
    delta_q <= delta_d;
    lim_q   <= lim_d;
  end

  assign sum_o = acc_q;

endmodule

// File: src/fpst_port_checker.sv
// Port-level checks of the prefix sum table core, bound to its top level.
// Depends on fpst_pkg and the assertion macros in fenwick_prefix_sum_table_core_assert.svh.
`include "fenwick_prefix_sum_table_core_assert.svh"

module fpst_port_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [fpst_pkg::DATA_W-1:0]        prefix_sum_o
);

  // A stalled result stays offered with the same value.
  `FPST_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o,
    "result dropped while stalled")
  `FPST_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i,
    $stable(prefix_sum_o), "stalled result changed")
  // A taken request starts a walk, and in_ready_o is low while the walk is under way.
  `FPST_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o,
    "request taken while a walk is under way")
  // A new result is handed over only once the walk has finished.
  `FPST_ASSERT_NOW(a_idle_on_result, clk_i, rst_ni, $rose(out_valid_o), in_ready_o,
    "result shown while the walker is still busy")

endmodule

bind fenwick_prefix_sum_table_core fpst_port_checker u_port_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .prefix_sum_o (prefix_sum_o)
);
